### rtl/core/smau_pkg.sv
// package for the square matrix arithmetic unit
// shared transaction types, kind and mode codes; no dependencies
package smau_pkg;

    localparam logic [1:0] KIND_WR_A  = 2'd0;
    localparam logic [1:0] KIND_WR_B  = 2'd1;
    localparam logic [1:0] KIND_START = 2'd2;

    localparam logic [2:0] MODE_ADD  = 3'd0;
    localparam logic [2:0] MODE_SUB  = 3'd1;
    localparam logic [2:0] MODE_MUL  = 3'd2;
    localparam logic [2:0] MODE_ADDS = 3'd3;
    localparam logic [2:0] MODE_SUBS = 3'd4;
    localparam logic [2:0] MODE_SCL  = 3'd5;

    localparam logic [1:0] CFG_SIZE   = 2'd0;
    localparam logic [1:0] CFG_MODE   = 2'd1;
    localparam logic [1:0] CFG_SCALAR = 2'd2;

    localparam logic [3:0] RESET_SIZE = 4'd5;

    // command queued between front and back
    typedef struct packed {
        logic [1:0]  kind;
        logic [2:0]  row;
        logic [2:0]  col;
        logic [31:0] value;
    } t_cmd;

    // result element waiting in the output queue
    typedef struct packed {
        logic [2:0]  row;
        logic [2:0]  col;
        logic [31:0] value;
        logic        last;
    } t_res;

    // queue handshake from front to back
    typedef struct packed {
        logic valid;
        t_cmd cmd;
    } t_cmd_q;

endpackage

### rtl/core/smau_ram.sv
// generic single write port ram with registered read
// no dependencies
module smau_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                             i_clk,
    input  logic                             i_we,
    input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                 i_wdata,
    input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] i_raddr,
    output logic [WIDTH-1:0]                 o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    // write and registered read
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule

### rtl/core/smau_front.sv
// front part: accepts input transactions, drops ignored ones, queues commands
// depends on smau_pkg
module smau_front #(
    parameter int MAX_DIM = 8
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           push,
    output logic           full,
    input  smau_pkg::t_cmd i_cmd,
    output smau_pkg::t_cmd_q o_q,
    input  logic           i_q_pop
);
    import smau_pkg::*;

    localparam int DEPTH = 4;

    t_cmd       r_buf [DEPTH];
    logic [1:0] r_wp, r_rp;
    logic [2:0] r_cnt;
    logic       w_acc, w_keep, w_enq, w_deq;

    // classify: unused kind and out-of-range writes are dropped
    assign w_acc  = push && !full;
    assign w_keep = (i_cmd.kind == KIND_START) ||
                    ((i_cmd.kind == KIND_WR_A || i_cmd.kind == KIND_WR_B) &&
                     (32'(i_cmd.row) < MAX_DIM) && (32'(i_cmd.col) < MAX_DIM));
    assign w_enq  = w_acc && w_keep;
    assign w_deq  = i_q_pop && (r_cnt != 3'd0);
    assign full   = (r_cnt == 3'(DEPTH));

    assign o_q.valid = (r_cnt != 3'd0);
    assign o_q.cmd   = r_buf[r_rp];

    // command queue storage
    always_ff @(posedge i_clk) begin
        if (w_enq) begin
            r_buf[r_wp] <= i_cmd;
        end
    end

    // queue pointers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (w_enq) r_wp <= r_wp + 2'd1;
            if (w_deq) r_rp <= r_rp + 2'd1;
            r_cnt <= r_cnt + 3'(w_enq) - 3'(w_deq);
        end
    end
endmodule

### rtl/core/smau_back.sv
// back part: owns the matrix rams, sequences each operation, queues results
// depends on smau_pkg and smau_ram
module smau_back #(
    parameter int MAX_DIM = 8
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  smau_pkg::t_cmd_q i_q,
    output logic             o_q_pop,
    input  logic [3:0]       i_size,
    input  logic [2:0]       i_mode,
    input  logic [31:0]      i_scalar,
    output logic             empty,
    input  logic             pop,
    output smau_pkg::t_res   o_res
);
    import smau_pkg::*;

    localparam int DEPTH = MAX_DIM * MAX_DIM;
    localparam int AW    = $clog2(DEPTH > 1 ? DEPTH : 2);

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_ISSUE = 2'd1;
    localparam logic [1:0] S_FIN   = 2'd2;

    logic [1:0]  r_state;
    logic [2:0]  r_i, r_j, r_r;
    logic [3:0]  w_n, w_steps;
    logic        w_mul;
    logic [AW-1:0] w_ra, w_rb, w_wa;
    logic [31:0] w_da, w_db;
    logic        w_we_a, w_we_b, w_push, w_last, w_pipe_busy;

    logic        r_v1, r_first1, r_v2, r_first2, r_mul2, r_v3, r_first3;
    logic signed [63:0] r_prod, r_term, r_acc, w_term;
    logic signed [33:0] r_sum, w_sum;
    logic signed [31:0] w_sa, w_sop, w_sat;

    t_res       r_obuf [2];
    logic       r_owp, r_orp;
    logic [1:0] r_ocnt;
    logic       w_ofull, w_odeq;

    // effective size and step count
    assign w_n     = (i_size == 4'd0) ? 4'd1 :
                     (32'(i_size) > MAX_DIM) ? 4'(MAX_DIM) : i_size;
    assign w_mul   = (i_mode == MODE_MUL);
    assign w_steps = w_mul ? w_n : 4'd1;
    assign w_last  = (4'(r_i) == w_n - 4'd1) && (4'(r_j) == w_n - 4'd1);

    // ram ports
    assign w_wa   = AW'(32'(i_q.cmd.row) * MAX_DIM + 32'(i_q.cmd.col));
    assign w_ra   = AW'(32'(r_i) * MAX_DIM + 32'(w_mul ? r_r : r_j));
    assign w_rb   = AW'(32'(w_mul ? r_r : r_i) * MAX_DIM + 32'(r_j));
    assign o_q_pop = (r_state == S_IDLE) && i_q.valid;
    assign w_we_a = o_q_pop && (i_q.cmd.kind == KIND_WR_A);
    assign w_we_b = o_q_pop && (i_q.cmd.kind == KIND_WR_B);

    smau_ram #(.WIDTH(32), .DEPTH(DEPTH)) u_ram_a (
        .i_clk(i_clk), .i_we(w_we_a), .i_waddr(w_wa), .i_wdata(i_q.cmd.value),
        .i_raddr(w_ra), .o_rdata(w_da)
    );
    smau_ram #(.WIDTH(32), .DEPTH(DEPTH)) u_ram_b (
        .i_clk(i_clk), .i_we(w_we_b), .i_waddr(w_wa), .i_wdata(i_q.cmd.value),
        .i_raddr(w_rb), .o_rdata(w_db)
    );

    // sequencer
    assign w_pipe_busy = r_v1 || r_v2 || r_v3;
    assign w_push      = (r_state == S_FIN) && !w_pipe_busy && !w_ofull;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_i <= '0; r_j <= '0; r_r <= '0;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (o_q_pop && i_q.cmd.kind == KIND_START) begin
                        r_i <= '0; r_j <= '0; r_r <= '0;
                        r_state <= S_ISSUE;
                    end
                end
                S_ISSUE: begin
                    if (4'(r_r) == w_steps - 4'd1) begin
                        r_r <= '0;
                        r_state <= S_FIN;
                    end else begin
                        r_r <= r_r + 3'd1;
                    end
                end
                S_FIN: begin
                    if (w_push) begin
                        if (w_last) begin
                            r_state <= S_IDLE;
                        end else begin
                            r_state <= S_ISSUE;
                            if (4'(r_j) == w_n - 4'd1) begin
                                r_j <= '0;
                                r_i <= r_i + 3'd1;
                            end else begin
                                r_j <= r_j + 3'd1;
                            end
                        end
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // pipeline valid flags
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0; r_v2 <= 1'b0; r_v3 <= 1'b0;
        end else begin
            r_v1 <= (r_state == S_ISSUE);
            r_v2 <= r_v1;
            r_v3 <= r_v2;
        end
    end

    // stage 2: multiply or add/subtract on ram data
    assign w_sa  = $signed(w_da);
    assign w_sop = w_mul ? $signed(w_db) : $signed(i_scalar);

    always_comb begin
        case (i_mode)
            MODE_ADD:  w_sum = 34'(w_sa) + 34'($signed(w_db));
            MODE_SUB:  w_sum = 34'(w_sa) - 34'($signed(w_db));
            MODE_ADDS: w_sum = 34'(w_sa) + 34'($signed(i_scalar));
            MODE_SUBS: w_sum = 34'(w_sa) - 34'($signed(i_scalar));
            default:   w_sum = 34'(w_sa);
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_first1 <= (r_r == 3'd0);
        r_first2 <= r_first1;
        r_first3 <= r_first2;
        r_mul2   <= w_mul || (i_mode == MODE_SCL);
        r_prod   <= w_sa * w_sop;
        r_sum    <= w_sum;
    end

    // stage 3: round half up, stage 4: accumulate
    assign w_term = r_mul2 ? ((r_prod + 64'sd32768) >>> 16) : 64'(r_sum);

    always_ff @(posedge i_clk) begin
        r_term <= w_term;
        if (!i_rst_n) begin
            r_acc <= '0;
        end else if (r_v3) begin
            r_acc <= r_first3 ? r_term : r_acc + r_term;
        end
    end

    // saturate to 32 bits
    assign w_sat = (r_acc > 64'sd2147483647)  ? 32'sh7fffffff :
                   (r_acc < -64'sd2147483648) ? 32'sh80000000 : r_acc[31:0];

    // output queue
    assign w_ofull = (r_ocnt == 2'd2);
    assign w_odeq  = pop && !empty;
    assign empty   = (r_ocnt == 2'd0);
    assign o_res   = r_obuf[r_orp];

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_obuf[r_owp] <= '{row: r_i, col: r_j, value: w_sat, last: w_last};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_owp <= 1'b0; r_orp <= 1'b0; r_ocnt <= '0;
        end else begin
            if (w_push) r_owp <= ~r_owp;
            if (w_odeq) r_orp <= ~r_orp;
            r_ocnt <= r_ocnt + 2'(w_push) - 2'(w_odeq);
        end
    end
endmodule

### rtl/core/square_matrix_arithmetic_unit_top.sv
// Square matrix arithmetic unit. Element writes to A or B are taken one per
// cycle while the four-entry command queue is not full; a start transaction
// then computes n*n saturated Q16.16 results in row-major order (add,
// subtract, matrix product, scalar add, scalar subtract, scale; other mode
// codes pass A through). Each result element takes its read steps (n for the
// product, one otherwise) and then waits for the ram/multiply/round/accumulate
// pipeline to drain; a full two-entry result queue stalls the sequence, and
// the input shows full while the queue behind a start fills.
// depends on smau_pkg, smau_front, smau_back, smau_ram
module square_matrix_arithmetic_unit_top #(
    parameter int MAX_DIM = 8
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        push,
    output logic        full,
    input  logic [1:0]  i_kind,
    input  logic [2:0]  i_row,
    input  logic [2:0]  i_col,
    input  logic [31:0] i_value,
    output logic        empty,
    input  logic        pop,
    output logic [2:0]  o_out_row,
    output logic [2:0]  o_out_col,
    output logic [31:0] o_out_value,
    output logic        o_last,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_idx,
    input  logic [31:0] i_cfg_data
);
    import smau_pkg::*;

    logic [3:0]  r_size;
    logic [2:0]  r_mode;
    logic [31:0] r_scalar;
    t_cmd        w_cmd;
    t_cmd_q      w_q;
    logic        w_q_pop;
    t_res        w_res;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_size   <= RESET_SIZE;
            r_mode   <= MODE_ADD;
            r_scalar <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_SIZE:   r_size   <= i_cfg_data[3:0];
                CFG_MODE:   r_mode   <= i_cfg_data[2:0];
                CFG_SCALAR: r_scalar <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // input transaction fields
    assign w_cmd.kind  = i_kind;
    assign w_cmd.row   = i_row;
    assign w_cmd.col   = i_col;
    assign w_cmd.value = i_value;

    smau_front #(.MAX_DIM(MAX_DIM)) u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .push(push), .full(full),
        .i_cmd(w_cmd),
        .o_q(w_q), .i_q_pop(w_q_pop)
    );

    smau_back #(.MAX_DIM(MAX_DIM)) u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_q(w_q), .o_q_pop(w_q_pop),
        .i_size(r_size), .i_mode(r_mode), .i_scalar(r_scalar),
        .empty(empty), .pop(pop), .o_res(w_res)
    );

    assign o_out_row   = w_res.row;
    assign o_out_col   = w_res.col;
    assign o_out_value = w_res.value;
    assign o_last      = w_res.last;
endmodule

### rtl/core/smau_checker.sv
// port-level checks for the square matrix arithmetic unit
// depends on square_matrix_arithmetic_unit_top (bound below)
module smau_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        full,
    input logic        empty,
    input logic        pop,
    input logic [2:0]  o_out_row,
    input logic [2:0]  o_out_col,
    input logic [31:0] o_out_value,
    input logic        o_last
);
    // queues come out of reset empty
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> empty && !full) else $error("not empty after reset");

    // a waiting result holds while not taken
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty && !pop |=> !empty && $stable(o_out_value) && $stable(o_out_row))
        else $error("result changed while stalled");

    // the final element sits on the diagonal
    a_last_diag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty && o_last |-> o_out_row == o_out_col)
        else $error("last flag off the diagonal");

    // an off-diagonal element of the first row is never the last
    a_first_not_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty && o_out_row == 3'd0 && o_out_col != 3'd0 |-> !o_last)
        else $error("last flag on first row");
endmodule

bind square_matrix_arithmetic_unit_top smau_checker u_smau_checker (
    .i_clk(i_clk), .i_rst_n(i_rst_n), .full(full), .empty(empty), .pop(pop),
    .o_out_row(o_out_row), .o_out_col(o_out_col), .o_out_value(o_out_value),
    .o_last(o_last)
);

### tb/testbench.sv
// testbench for square_matrix_arithmetic_unit_top: loads A and B, starts every mode
// and checks each result element against a built-in Q16.16 matrix predictor
// depends on smau_pkg and the rtl of square_matrix_arithmetic_unit_top
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import smau_pkg::*;

    localparam int          DIM      = 8;
    localparam logic [1:0]  KIND_NOP = 2'd3;
    localparam logic [1:0]  CFG_NONE = 2'd3;
    localparam logic [2:0]  MODE_A6  = 3'd6;
    localparam logic [2:0]  MODE_A7  = 3'd7;
    localparam logic [31:0] Q_MAX    = 32'h7fff_ffff;
    localparam logic [31:0] Q_MIN    = 32'h8000_0000;
    localparam logic [31:0] Q_ONE    = 32'h0001_0000;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        push = 1'b0;
    logic        full;
    logic [1:0]  i_kind = '0;
    logic [2:0]  i_row = '0;
    logic [2:0]  i_col = '0;
    logic [31:0] i_value = '0;
    logic        empty;
    logic        pop = 1'b0;
    logic [2:0]  o_out_row;
    logic [2:0]  o_out_col;
    logic [31:0] o_out_value;
    logic        o_last;
    logic        i_cfg_we = 1'b0;
    logic [1:0]  i_cfg_idx = '0;
    logic [31:0] i_cfg_data = '0;

    // predictor state
    logic [31:0] mat_a [DIM*DIM];
    logic [31:0] mat_b [DIM*DIM];
    bit          a_set [DIM*DIM];
    bit          b_set [DIM*DIM];
    logic [3:0]  size_reg = RESET_SIZE;
    logic [2:0]  mode_reg = MODE_ADD;
    logic [31:0] scalar_reg = '0;
    t_res        pending_elems[$];

    int errors = 0;
    int items_sent = 0;
    int starts_sent = 0;
    int elems_checked = 0;
    int send_gap_pct = 0;
    int pop_stall_pct = 0;
    int hold_cycles = 0;

    square_matrix_arithmetic_unit_top #(.MAX_DIM(DIM)) DUT (.*);

    always #10 i_clk = ~i_clk;

    initial begin
        #20ms;
        $display("square_matrix_arithmetic_unit_top: mismatch");
        $finish;
    end

    // round half up product of two Q16.16 values
    function automatic longint q_mul(logic [31:0] x, logic [31:0] y);
        longint p;
        p = longint'($signed(x)) * longint'($signed(y)) + 64'sd32768;
        return p >>> 16;
    endfunction

    function automatic logic [31:0] clamp32(longint v);
        if (v > 64'sd2147483647) return Q_MAX;
        if (v < -64'sd2147483648) return Q_MIN;
        return v[31:0];
    endfunction

    function automatic int dim_used();
        if (size_reg == 0) return 1;
        if (size_reg > DIM) return DIM;
        return size_reg;
    endfunction

    // expected result matrix of one start transaction
    task automatic predict_matrix();
        int n;
        longint a, b, s, res, acc;
        t_res e;
        n = dim_used();
        s = longint'($signed(scalar_reg));
        for (int i = 0; i < n; i++) begin
            for (int j = 0; j < n; j++) begin
                a = longint'($signed(mat_a[i*DIM+j]));
                b = longint'($signed(mat_b[i*DIM+j]));
                case (mode_reg)
                    MODE_ADD:  res = a + b;
                    MODE_SUB:  res = a - b;
                    MODE_MUL: begin
                        acc = 0;
                        for (int r = 0; r < n; r++)
                            acc += q_mul(mat_a[i*DIM+r], mat_b[r*DIM+j]);
                        res = acc;
                    end
                    MODE_ADDS: res = a + s;
                    MODE_SUBS: res = a - s;
                    MODE_SCL:  res = q_mul(mat_a[i*DIM+j], scalar_reg);
                    default:   res = a;
                endcase
                e.row = i[2:0];
                e.col = j[2:0];
                e.value = clamp32(res);
                e.last = (i == n-1 && j == n-1);
                pending_elems.push_back(e);
            end
        end
    endtask

    // one input transaction, with optional idle gap before it
    task automatic send_item(logic [1:0] kind, logic [2:0] row, logic [2:0] col,
                             logic [31:0] value);
        int gap;
        gap = 0;
        if ($urandom_range(99) < send_gap_pct) gap = $urandom_range(1, 6);
        if (gap > 0) begin
            push <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        push <= 1'b1;
        i_kind <= kind;
        i_row <= row;
        i_col <= col;
        i_value <= value;
        do @(posedge i_clk); while (full);
        case (kind)
            KIND_WR_A: begin
                mat_a[row*DIM+col] = value;
                a_set[row*DIM+col] = 1'b1;
            end
            KIND_WR_B: begin
                mat_b[row*DIM+col] = value;
                b_set[row*DIM+col] = 1'b1;
            end
            KIND_START: begin
                predict_matrix();
                starts_sent++;
            end
            default: ;
        endcase
        if (kind != KIND_NOP) items_sent++;
    endtask

    // sender pauses until every expected element has come, then lets the block settle
    task automatic wait_drained();
        push <= 1'b0;
        while (pending_elems.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
    endtask

    task automatic cfg_write(logic [1:0] idx, logic [31:0] data);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            CFG_SIZE:   size_reg = data[3:0];
            CFG_MODE:   mode_reg = data[2:0];
            CFG_SCALAR: scalar_reg = data;
            default: ;
        endcase
    endtask

    function automatic logic [31:0] rand_q();
        case ($urandom_range(5))
            0: return Q_MAX;
            1: return Q_MIN;
            2: return $urandom_range(0, 32'h0004_0000) - 32'h0002_0000;
            3: return $urandom_range(0, 32'h0100_0000) - 32'h0080_0000;
            default: return $urandom;
        endcase
    endfunction

    // write every element of the used corner that has no value yet
    task automatic fill_corner();
        int n;
        n = dim_used();
        for (int i = 0; i < n; i++)
            for (int j = 0; j < n; j++) begin
                if (!a_set[i*DIM+j]) send_item(KIND_WR_A, 3'(i), 3'(j), rand_q());
                if (!b_set[i*DIM+j]) send_item(KIND_WR_B, 3'(i), 3'(j), rand_q());
            end
    endtask

    task automatic setup(logic [3:0] size, logic [2:0] mode, logic [31:0] scalar);
        wait_drained();
        cfg_write(CFG_SIZE, size);
        cfg_write(CFG_MODE, mode);
        cfg_write(CFG_SCALAR, scalar);
    endtask

    // result checker and pop driver
    always @(posedge i_clk) begin
        t_res e;
        if (i_rst_n && pop && !empty) begin
            if (pending_elems.size() == 0) begin
                $display("%0t: unexpected element row %0d col %0d value %h last %b",
                         $time, o_out_row, o_out_col, o_out_value, o_last);
                errors++;
            end else begin
                e = pending_elems.pop_front();
                elems_checked++;
                if (o_out_row !== e.row || o_out_col !== e.col
                        || o_out_value !== e.value || o_last !== e.last) begin
                    $display("%0t: expected row %0d col %0d value %h last %b",
                             $time, e.row, e.col, e.value, e.last);
                    $display("%0t: actual   row %0d col %0d value %h last %b",
                             $time, o_out_row, o_out_col, o_out_value, o_last);
                    errors++;
                end
            end
        end
        if (hold_cycles > 0) begin
            hold_cycles--;
            pop <= 1'b0;
        end else begin
            pop <= ($urandom_range(99) >= pop_stall_pct);
        end
    end

    // single-element matrices at the value extremes, every mode
    task automatic test_extremes();
        setup(4'd1, MODE_ADD, 32'h0);
        cfg_write(CFG_NONE, 32'hffff_ffff);
        send_item(KIND_WR_A, 0, 0, Q_MAX);
        send_item(KIND_WR_B, 0, 0, Q_MAX);
        send_item(KIND_START, 0, 0, 0);
        send_item(KIND_NOP, 7, 7, 32'hdead_beef);
        setup(4'd1, MODE_SUB, 32'h0);
        send_item(KIND_WR_A, 0, 0, Q_MIN);
        send_item(KIND_START, 0, 0, 0);
        setup(4'd1, MODE_MUL, 32'h0);
        send_item(KIND_START, 0, 0, 0);
        send_item(KIND_WR_A, 0, 0, 32'hffff_8000);
        send_item(KIND_WR_B, 0, 0, 32'h0000_8000);
        send_item(KIND_START, 0, 0, 0);
        setup(4'd0, MODE_ADDS, Q_MAX);
        send_item(KIND_START, 0, 0, 0);
        setup(4'd1, MODE_SUBS, Q_MIN);
        send_item(KIND_START, 0, 0, 0);
        setup(4'd1, MODE_SCL, Q_MIN);
        send_item(KIND_START, 0, 0, 0);
        setup(4'd1, MODE_A6, Q_ONE);
        send_item(KIND_START, 0, 0, 0);
        setup(4'd1, MODE_A7, Q_ONE);
        send_item(KIND_START, 0, 0, 0);
    endtask

    // receiver holds off long while the sender keeps offering, then drains
    task automatic test_backpressure();
        setup(4'd3, MODE_MUL, 32'h0);
        fill_corner();
        hold_cycles = 400;
        send_item(KIND_START, 0, 0, 0);
        for (int k = 0; k < 12; k++)
            send_item($urandom_range(1) ? KIND_WR_A : KIND_WR_B,
                      3'($urandom_range(7)), 3'($urandom_range(7)), rand_q());
        send_item(KIND_START, 0, 0, 0);
        wait_drained();
    endtask

    // random configurations, random writes and ignored items, then one or two starts
    task automatic test_random(int count, int gap_pct, int stall_pct);
        int stop_at;
        logic [3:0] size;
        stop_at = items_sent + count;
        send_gap_pct = gap_pct;
        pop_stall_pct = stall_pct;
        while (items_sent < stop_at) begin
            size = ($urandom_range(11) == 0) ? 4'($urandom_range(8, 15))
                                             : 4'($urandom_range(0, 4));
            setup(size, 3'($urandom_range(7)), rand_q());
            repeat ($urandom_range(0, 6)) begin
                if ($urandom_range(9) == 0)
                    send_item(KIND_NOP, 3'($urandom_range(7)), 3'($urandom_range(7)),
                              $urandom);
                else
                    send_item($urandom_range(1) ? KIND_WR_A : KIND_WR_B,
                              3'($urandom_range(7)), 3'($urandom_range(7)), rand_q());
            end
            fill_corner();
            send_item(KIND_START, 0, 0, 0);
            if ($urandom_range(3) == 0) send_item(KIND_START, 0, 0, 0);
        end
    endtask

    initial begin
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_extremes();
        test_backpressure();
        test_random(75, 0, 0);
        test_random(75, 81, 0);
        test_random(75, 0, 81);
        test_random(75, 19, 19);
        wait_drained();
        repeat (50) @(posedge i_clk);
        $display("covered %0d input transactions and %0d starts, %0d elements checked",
                 items_sent, starts_sent, elems_checked);
        $display("all six modes, unused modes, size clamping and input back-pressure");
        if (errors == 0 && pending_elems.size() == 0)
            $display("square_matrix_arithmetic_unit_top: match");
        else
            $display("square_matrix_arithmetic_unit_top: mismatch");
        $finish;
    end

endmodule
